FILE: rtl/lfu_cache_lru_tiebreak_core_assert.svh
// Assertion macros used by the cache core RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef LFU_CACHE_LRU_TIEBREAK_CORE_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LFUC_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFUC_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/lfuc_pkg.sv
// Shared constants and types for the LFU cache core.
// No dependencies; imported by the scan unit and the top level.
`timescale 1ns / 1ps

package lfuc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 64;

	localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [VAL_W-1:0]   MISS_VALUE = '1;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One read returning from the entry memory.
	typedef struct packed {
		logic             strobe;
		logic [IDX_W-1:0] idx;
		logic             valid;
	} scan_rd_t;

	// What the scan has found after all entries went by.
	typedef struct packed {
		logic               match_found;
		logic [IDX_W-1:0]   match_idx;
		logic [VAL_W-1:0]   match_value;
		logic [COUNT_W-1:0] match_count;
		logic               victim_found;
		logic [IDX_W-1:0]   victim_idx;
		logic               free_found;
		logic [IDX_W-1:0]   free_idx;
		logic [CNT_W-1:0]   used;
	} scan_res_t;

endpackage

FILE: rtl/lfuc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfuc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/lfuc_scan.sv
// Scan unit: walks the entry memory read data one entry per cycle and keeps
// the key match, the LFU/LRU victim, the lowest free slot and the occupancy.
// Depends on lfuc_pkg.
`timescale 1ns / 1ps

module lfuc_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  lfuc_pkg::scan_rd_t              rd,
	input  lfuc_pkg::entry_t                rdata,
	input  logic [lfuc_pkg::KEY_W-1:0]      key,
	output lfuc_pkg::scan_res_t             res
);

	import lfuc_pkg::*;

	logic               match_found_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [VAL_W-1:0]   match_value_q;
	logic [COUNT_W-1:0] match_count_q;
	logic               victim_found_q;
	logic [IDX_W-1:0]   victim_idx_q;
	logic [COUNT_W-1:0] victim_count_q;
	logic [STAMP_W-1:0] victim_stamp_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [CNT_W-1:0]   used_q;

	logic hit_now;
	logic older;
	logic victim_now;
	logic free_now;

	assign hit_now = rd.strobe && rd.valid && (rdata.key == key) && !match_found_q;

	// Smaller count wins; equal counts go to the older stamp, first slot on a full tie.
	assign older = !victim_found_q || (rdata.count < victim_count_q) ||
		((rdata.count == victim_count_q) && (rdata.stamp < victim_stamp_q));
	assign victim_now = rd.strobe && rd.valid && older;
	assign free_now   = rd.strobe && !rd.valid && !free_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q  <= 1'b0;
			victim_found_q <= 1'b0;
			free_found_q   <= 1'b0;
			used_q         <= '0;
		end else if (clear) begin
			match_found_q  <= 1'b0;
			victim_found_q <= 1'b0;
			free_found_q   <= 1'b0;
			used_q         <= '0;
		end else begin
			if (hit_now) begin
				match_found_q <= 1'b1;
			end
			if (victim_now) begin
				victim_found_q <= 1'b1;
			end
			if (free_now) begin
				free_found_q <= 1'b1;
			end
			if (rd.strobe && rd.valid) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_now) begin
			match_idx_q   <= rd.idx;
			match_value_q <= rdata.value;
			match_count_q <= rdata.count;
		end
		if (victim_now) begin
			victim_idx_q   <= rd.idx;
			victim_count_q <= rdata.count;
			victim_stamp_q <= rdata.stamp;
		end
		if (free_now) begin
			free_idx_q <= rd.idx;
		end
	end

	always_comb begin
		res.match_found  = match_found_q;
		res.match_idx    = match_idx_q;
		res.match_value  = match_value_q;
		res.match_count  = match_count_q;
		res.victim_found = victim_found_q;
		res.victim_idx   = victim_idx_q;
		res.free_found   = free_found_q;
		res.free_idx     = free_idx_q;
		res.used         = used_q;
	end

endmodule

FILE: rtl/lfu_cache_lru_tiebreak_core.sv
// LFU cache with LRU tie break: each item is scanned one entry per cycle over the
// entry memory read port, then passes drain and write-back before the next is accepted.
// A result is registered at write-back and may wait in the output register while
// the next word is already accepted and scanned.
// Reset clears valid bits, the use clock and the sequencer; capacity returns to 16.
// No memory clearing pass: entries are qualified by flip-flop valid bits.
`timescale 1ns / 1ps
`include "lfu_cache_lru_tiebreak_core_assert.svh"

module lfu_cache_lru_tiebreak_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lfuc_pkg::CAP_W-1:0]          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic signed [lfuc_pkg::KEY_W-1:0]   key,
	input  logic signed [lfuc_pkg::VAL_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic signed [lfuc_pkg::VAL_W-1:0]   read_value
);

	import lfuc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_WB    = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [1:0]         state_q;
	logic [CAP_W-1:0]   cap_q;
	logic [ENTRIES-1:0] valid_q;
	logic [STAMP_W-1:0] use_clock_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   value_q;
	logic               out_valid_q;
	logic               hit_q;
	logic [VAL_W-1:0]   read_value_q;

	logic               accept;
	logic               wb_go;
	logic               use_victim;
	logic               slot_ok;
	logic               do_insert;
	logic               mem_we;
	logic [IDX_W-1:0]   ins_slot;
	logic [IDX_W-1:0]   mem_waddr;
	logic [COUNT_W-1:0] count_inc;
	entry_t             mem_wdata;
	entry_t             mem_rdata;
	scan_rd_t           scan_rd;
	scan_res_t          res;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign wb_go    = (state_q == ST_WB) && (!out_valid_q || !out_stall);

	// Evict only when the in-use count has reached the clipped capacity.
	always_comb begin
		logic [CMP_W-1:0] cap_eff;
		cap_eff = (CMP_W'(cap_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_q);
		use_victim = (CMP_W'(res.used) >= cap_eff) && res.victim_found;
	end

	assign ins_slot  = use_victim ? res.victim_idx : res.free_idx;
	assign slot_ok   = use_victim || res.free_found;
	assign do_insert = (mode_q == MODE_PUT) && (cap_q != '0) && !res.match_found && slot_ok;
	assign mem_we    = wb_go && (((mode_q == MODE_GET) && res.match_found) ||
		((mode_q == MODE_PUT) && (cap_q != '0) && res.match_found) || do_insert);
	assign mem_waddr = res.match_found ? res.match_idx : ins_slot;
	assign count_inc = (res.match_count == COUNT_MAX) ? COUNT_MAX :
		res.match_count + COUNT_W'(1);

	always_comb begin
		mem_wdata.key   = key_q;
		mem_wdata.value = (mode_q == MODE_PUT) ? value_q : res.match_value;
		mem_wdata.count = res.match_found ? count_inc : COUNT_W'(1);
		mem_wdata.stamp = use_clock_q;
	end

	assign scan_rd.strobe = rd_vld_s1;
	assign scan_rd.idx    = rd_idx_s1;
	assign scan_rd.valid  = valid_q[rd_idx_s1];

	lfuc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_idx_q),
		.rdata(mem_rdata)
	);

	lfuc_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (accept),
		.rd    (scan_rd),
		.rdata (mem_rdata),
		.key   (key_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			valid_q     <= '0;
			use_clock_q <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (wb_go && do_insert) begin
				valid_q[ins_slot] <= 1'b1;
			end
			if (mem_we) begin
				use_clock_q <= use_clock_q + STAMP_W'(1);
			end
			// Hold the word until taken, reload on write-back.
			if (wb_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		if (accept) begin
			mode_q  <= mode;
			key_q   <= key;
			value_q <= value;
		end
		if (wb_go) begin
			hit_q <= res.match_found;
			if (mode_q == MODE_PUT) begin
				read_value_q <= '0;
			end else begin
				read_value_q <= res.match_found ? res.match_value : MISS_VALUE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	`LFUC_ASSERT_IMP(a_hit_valid, wb_go && res.match_found, valid_q[res.match_idx],
		"hit on an entry whose valid bit is clear")
	`LFUC_ASSERT_IMP(a_insert_slot, wb_go && (mode_q == MODE_PUT) && (cap_q != '0) &&
		!res.match_found, slot_ok, "insert found neither a free slot nor a victim")
	`LFUC_ASSERT_NXT(a_clock_step, mem_we, use_clock_q == $past(use_clock_q) + STAMP_W'(1),
		"use clock did not advance by one on an entry update")
	`LFUC_ASSERT_IMP(a_out_from_wb, $rose(out_valid_q), $past(state_q) == ST_WB,
		"output word raised outside write-back")

endmodule
